// ===== sv/calu_pkg.sv =====
// calu_pkg: shared types and constants for the 8/16-bit cpu alu with flags
// holds the operation codes, flag bit positions and the request/response structs
// no dependencies
package calu_pkg;

  // operation codes
  typedef enum logic [5:0] {
    OP_ADD    = 6'd0,
    OP_ADC    = 6'd1,
    OP_SUB    = 6'd2,
    OP_SBC    = 6'd3,
    OP_AND    = 6'd4,
    OP_XOR    = 6'd5,
    OP_OR     = 6'd6,
    OP_CP     = 6'd7,
    OP_INC    = 6'd8,
    OP_DEC    = 6'd9,
    OP_DAA    = 6'd10,
    OP_CPL    = 6'd11,
    OP_RL     = 6'd12,
    OP_RR     = 6'd13,
    OP_RLC    = 6'd14,
    OP_RRC    = 6'd15,
    OP_RLA    = 6'd16,
    OP_RRA    = 6'd17,
    OP_RLCA   = 6'd18,
    OP_RRCA   = 6'd19,
    OP_SLA    = 6'd20,
    OP_SRA    = 6'd21,
    OP_SRL    = 6'd22,
    OP_SWAP   = 6'd23,
    OP_BIT    = 6'd24,
    OP_SET    = 6'd25,
    OP_RES    = 6'd26,
    OP_CCF    = 6'd27,
    OP_SCF    = 6'd28,
    OP_ADD16  = 6'd29,
    OP_ADDSP  = 6'd30,
    OP_INC16  = 6'd31,
    OP_DEC16  = 6'd32
  } calu_op_t;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // decimal adjust constants
  localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HI_LIM  = 8'h99;
  localparam logic [3:0] DAA_LO_LIM  = 4'h9;

  // one request
  typedef struct packed {
    logic [5:0]  cmd;
    logic [15:0] left_operand;
    logic [15:0] right_operand;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } calu_req_t;

  // one response
  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        result_valid;
  } calu_rsp_t;

endpackage

// ===== sv/cpu_alu_with_flags.sv =====
// cpu_alu_with_flags: 8/16-bit cpu alu with z/n/h/c flags behind a valid/stall pipeline
// a request reaches the result through the input register, then the result register
// throughput one request per cycle; in_stall only rises while both stages hold
// a request and the output is stalled
// rst_n synchronous active low clears both stage valid bits; no other state
// uses calu_pkg and calu_core
module cpu_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_cmd,
  input  logic [15:0] in_left_operand,
  input  logic [15:0] in_right_operand,
  input  logic [2:0]  in_bit_index,
  input  logic [3:0]  in_flags_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result,
  output logic [3:0]  out_flags_out,
  output logic        out_result_valid
);
  import calu_pkg::*;

  logic      req_vld_r;
  logic      req_vld_nxt;
  calu_req_t req_r;
  logic      rsp_vld_r;
  logic      rsp_vld_nxt;
  calu_rsp_t rsp_r;
  calu_rsp_t rsp_comb;
  logic      rsp_take;
  logic      req_take;

  // stage advance
  assign rsp_take    = !rsp_vld_r || !out_stall;
  assign req_take    = !req_vld_r || rsp_take;
  assign in_stall    = !req_take;
  assign req_vld_nxt = req_take ? in_valid : req_vld_r;
  assign rsp_vld_nxt = rsp_take ? req_vld_r : rsp_vld_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      rsp_vld_r <= rsp_vld_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_r.cmd           <= in_cmd;
      req_r.left_operand  <= in_left_operand;
      req_r.right_operand <= in_right_operand;
      req_r.bit_index     <= in_bit_index;
      req_r.flags_in      <= in_flags_in;
    end
  end

  calu_core u_core (
    .req (req_r),
    .rsp (rsp_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rsp_take) begin
      rsp_r <= rsp_comb;
    end
  end

  assign out_valid        = rsp_vld_r;
  assign out_result       = rsp_r.result;
  assign out_flags_out    = rsp_r.flags_out;
  assign out_result_valid = rsp_r.result_valid;

endmodule

// ===== sv/calu_core.sv =====
// calu_core: combinational datapath of the cpu alu, one request to one response
// uses calu_pkg for opcodes, flag positions and structs
module calu_core (
  input  calu_pkg::calu_req_t req,
  output calu_pkg::calu_rsp_t rsp
);
  import calu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        use_c;
  logic [8:0]  add9;
  logic [8:0]  sub9;
  logic [7:0]  bit_mask;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_res;
  logic        daa_c;
  logic [16:0] add17;
  logic [15:0] sp_sum;
  logic [4:0]  sp_nib;
  logic [8:0]  sp_byte;
  logic [7:0]  res8;
  logic [15:0] res16;
  logic        is8;
  logic        fz;
  logic        fn;
  logic        fh;
  logic        fc;
  logic        keep_z;
  logic        wr;

  assign a   = req.left_operand[7:0];
  assign b   = req.right_operand[7:0];
  assign cin = req.flags_in[FLAG_C];

  // carry or borrow in only for the with-carry forms
  assign use_c = cin && (req.cmd == OP_ADC || req.cmd == OP_SBC);
  assign add9  = {1'b0, a} + {1'b0, b} + {8'b0, use_c};
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'b0, use_c};

  assign bit_mask = 8'd1 << req.bit_index;

  // decimal adjust after add or subtract
  assign daa_hi = cin || (a > DAA_HI_LIM);
  assign daa_lo = req.flags_in[FLAG_H] || (a[3:0] > DAA_LO_LIM);
  always_comb begin
    if (!req.flags_in[FLAG_N]) begin
      daa_res = a + (daa_hi ? DAA_HI_ADJ : 8'h00) + (daa_lo ? DAA_LO_ADJ : 8'h00);
      daa_c   = daa_hi;
    end else begin
      daa_res = a - (cin ? DAA_HI_ADJ : 8'h00)
                  - (req.flags_in[FLAG_H] ? DAA_LO_ADJ : 8'h00);
      daa_c   = cin;
    end
  end

  // 16-bit adders
  assign add17   = {1'b0, req.left_operand} + {1'b0, req.right_operand};
  assign sp_sum  = req.left_operand + {{8{b[7]}}, b};
  assign sp_nib  = {1'b0, req.left_operand[3:0]} + {1'b0, b[3:0]};
  assign sp_byte = {1'b0, req.left_operand[7:0]} + {1'b0, b};

  // operation select
  always_comb begin
    res8   = a;
    res16  = req.left_operand;
    is8    = 1'b1;
    keep_z = 1'b0;
    fz     = req.flags_in[FLAG_Z];
    fn     = req.flags_in[FLAG_N];
    fh     = req.flags_in[FLAG_H];
    fc     = req.flags_in[FLAG_C];
    wr     = 1'b1;
    case (req.cmd) inside
      OP_ADD, OP_ADC: begin
        res8 = add9[7:0];
        fn   = 1'b0;
        fh   = a[4] ^ b[4] ^ add9[4];
        fc   = add9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        res8 = (req.cmd == OP_CP) ? a : sub9[7:0];
        wr   = (req.cmd != OP_CP);
        keep_z = 1'b1;
        fz   = (sub9[7:0] == 8'h00);
        fn   = 1'b1;
        fh   = a[4] ^ b[4] ^ sub9[4];
        fc   = sub9[8];
      end
      OP_AND: begin
        res8 = a & b;
        fn = 1'b0; fh = 1'b1; fc = 1'b0;
      end
      OP_XOR: begin
        res8 = a ^ b;
        fn = 1'b0; fh = 1'b0; fc = 1'b0;
      end
      OP_OR: begin
        res8 = a | b;
        fn = 1'b0; fh = 1'b0; fc = 1'b0;
      end
      OP_INC: begin
        res8 = a + 8'd1;
        fn = 1'b0; fh = (a[3:0] == 4'hF);
      end
      OP_DEC: begin
        res8 = a - 8'd1;
        fn = 1'b1; fh = (a[3:0] == 4'h0);
      end
      OP_DAA: begin
        res8 = daa_res;
        fh = 1'b0; fc = daa_c;
      end
      OP_CPL: begin
        res8 = ~a;
        keep_z = 1'b1;
        fn = 1'b1; fh = 1'b1;
      end
      OP_RL, OP_RLA: begin
        res8 = {a[6:0], cin};
        fn = 1'b0; fh = 1'b0; fc = a[7];
      end
      OP_RR, OP_RRA: begin
        res8 = {cin, a[7:1]};
        fn = 1'b0; fh = 1'b0; fc = a[0];
      end
      OP_RLC, OP_RLCA: begin
        res8 = {a[6:0], a[7]};
        fn = 1'b0; fh = 1'b0; fc = a[7];
      end
      OP_RRC, OP_RRCA: begin
        res8 = {a[0], a[7:1]};
        fn = 1'b0; fh = 1'b0; fc = a[0];
      end
      OP_SLA: begin
        res8 = {a[6:0], 1'b0};
        fn = 1'b0; fh = 1'b0; fc = a[7];
      end
      OP_SRA: begin
        res8 = {a[7], a[7:1]};
        fn = 1'b0; fh = 1'b0; fc = a[0];
      end
      OP_SRL: begin
        res8 = {1'b0, a[7:1]};
        fn = 1'b0; fh = 1'b0; fc = a[0];
      end
      OP_SWAP: begin
        res8 = {a[3:0], a[7:4]};
        fn = 1'b0; fh = 1'b0; fc = 1'b0;
      end
      OP_BIT: begin
        wr = 1'b0;
        keep_z = 1'b1;
        fz = ((a & bit_mask) == 8'h00);
        fn = 1'b0; fh = 1'b1;
      end
      OP_SET: begin
        res8 = a | bit_mask;
        keep_z = 1'b1;
      end
      OP_RES: begin
        res8 = a & ~bit_mask;
        keep_z = 1'b1;
      end
      OP_CCF: begin
        wr = 1'b0;
        keep_z = 1'b1;
        fn = 1'b0; fh = 1'b0; fc = ~cin;
      end
      OP_SCF: begin
        wr = 1'b0;
        keep_z = 1'b1;
        fn = 1'b0; fh = 1'b0; fc = 1'b1;
      end
      OP_ADD16: begin
        is8 = 1'b0;
        res16 = add17[15:0];
        keep_z = 1'b1;
        fn = 1'b0;
        fh = req.left_operand[12] ^ req.right_operand[12] ^ add17[12];
        fc = add17[16];
      end
      OP_ADDSP: begin
        is8 = 1'b0;
        res16 = sp_sum;
        keep_z = 1'b1;
        fz = 1'b0; fn = 1'b0; fh = sp_nib[4]; fc = sp_byte[8];
      end
      OP_INC16: begin
        is8 = 1'b0;
        keep_z = 1'b1;
        res16 = req.left_operand + 16'd1;
      end
      OP_DEC16: begin
        is8 = 1'b0;
        keep_z = 1'b1;
        res16 = req.left_operand - 16'd1;
      end
      default: begin
        // unused codes pass the operand through untouched
        is8 = 1'b0;
        keep_z = 1'b1;
        wr = 1'b0;
      end
    endcase
  end

  // zero flag from the 8-bit result unless the operation sets or keeps it; cleared for rla, rra, rlca, rrca
  always_comb begin
    rsp.result       = is8 ? {8'h00, res8} : res16;
    rsp.flags_out    = 4'h0;
    rsp.result_valid = wr;
    rsp.flags_out[FLAG_Z] = keep_z ? fz : (res8 == 8'h00);
    if (req.cmd inside {OP_RLA, OP_RRA, OP_RLCA, OP_RRCA}) begin
      rsp.flags_out[FLAG_Z] = 1'b0;
    end
    rsp.flags_out[FLAG_N] = fn;
    rsp.flags_out[FLAG_H] = fh;
    rsp.flags_out[FLAG_C] = fc;
  end

endmodule

// ===== sv/calu_checker.sv =====
// calu_checker: port-level assertions for cpu_alu_with_flags, bound to the top level
// uses calu_pkg for opcode names
module calu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [5:0]  in_cmd,
  input logic [15:0] in_left_operand,
  input logic [3:0]  in_flags_in,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_result,
  input logic [3:0]  out_flags_out,
  input logic        out_result_valid
);
  import calu_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result)
      && $stable(out_flags_out) && $stable(out_result_valid))
    else $error("stalled result changed");

  // no back-pressure while the output stage is empty
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");

  // a result follows an accepted request through the input and result registers with a free output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 !out_stall |=> out_valid)
    else $error("result missing two cycles after request");

  // unused codes pass through without write-back
  a_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd > 6'(OP_DEC16)) ##1 !out_stall |=>
      !out_result_valid && out_result == $past(in_left_operand, 2)
      && out_flags_out == $past(in_flags_in, 2))
    else $error("unused code not passed through");

  // compare and bit test never write back
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == 6'(OP_CP) || in_cmd == 6'(OP_BIT))) ##1 !out_stall |=>
      !out_result_valid)
    else $error("compare or bit test wrote back");

endmodule

bind cpu_alu_with_flags calu_checker u_calu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_cmd           (in_cmd),
  .in_left_operand  (in_left_operand),
  .in_flags_in      (in_flags_in),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result       (out_result),
  .out_flags_out    (out_flags_out),
  .out_result_valid (out_result_valid)
);
